// ===== sv/jsaf_pkg.sv =====
// Shared types and constants for the JSON string ASCII folder.
// Used by the front decoder, the entry queue, the write sequencer and the top level.
package jsaf_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned CHAR_SLOTS = 4;

   localparam logic [8:0] SIZE_CAP   = 9'd256;
   localparam logic [8:0] SIZE_RESET = 9'd256;

   localparam logic [6:0] CH_NUL   = 7'h00;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_DOT   = 7'h2E;
   localparam logic [6:0] CH_QMARK = 7'h3F;

   typedef enum logic [2:0] {
      ESC_IDLE,
      ESC_BACKSLASH,
      ESC_HEX0,
      ESC_HEX1,
      ESC_HEX2,
      ESC_HEX3
   } esc_phase_type;

   typedef struct packed {
      logic [2:0]                  n;
      logic [CHAR_SLOTS-1:0][6:0]  chars;
      logic                        term;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== sv/jsaf_front.sv =====
// Front decoder: UTF-8 and escape decoding, folding to ASCII, per-item character lists.
// Depends on jsaf_pkg; feeds jsaf_queue.
module jsaf_front
   import jsaf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       has_byte,
   input  logic [7:0] in_byte,
   input  logic       final_req,
   output logic       push,
   output entry_type  push_entry
);

   typedef struct packed {
      logic [1:0]      n;
      logic [2:0][6:0] chars;
   } fold_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b inside {[8'h30:8'h39]}) begin
         h.val = 4'(b - 8'h30);
      end else if (b inside {[8'h61:8'h66]}) begin
         h.val = 4'(b - 8'h57);
      end else if (b inside {[8'h41:8'h46]}) begin
         h.val = 4'(b - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic fold_type fold_code(input logic [20:0] cp);
      fold_type f;
      f.n     = 2'd1;
      f.chars = {3{CH_QMARK}};
      if (cp >= 21'h20 && cp < 21'h7F) begin
         f.chars[0] = cp[6:0];
      end else if (cp == 21'h2026) begin
         f.n     = 2'd3;
         f.chars = {3{CH_DOT}};
      end else begin
         case (cp) inside
            21'h0E0, 21'h0E2, 21'h0E4:           f.chars[0] = 7'h61;
            21'h0E7:                             f.chars[0] = 7'h63;
            21'h0E8, 21'h0E9, 21'h0EA, 21'h0EB:  f.chars[0] = 7'h65;
            21'h0EE, 21'h0EF:                    f.chars[0] = 7'h69;
            21'h0F4, 21'h0F6:                    f.chars[0] = 7'h6F;
            21'h0F9, 21'h0FB, 21'h0FC:           f.chars[0] = 7'h75;
            21'h0C0, 21'h0C2:                    f.chars[0] = 7'h41;
            21'h0C7:                             f.chars[0] = 7'h43;
            21'h0C8, 21'h0C9, 21'h0CA, 21'h0CB:  f.chars[0] = 7'h45;
            21'h0CE, 21'h0CF:                    f.chars[0] = 7'h49;
            21'h0D4:                             f.chars[0] = 7'h4F;
            21'h0D9, 21'h0DB:                    f.chars[0] = 7'h55;
            21'h153: begin
               f.n = 2'd2; f.chars[0] = 7'h6F; f.chars[1] = 7'h65;
            end
            21'h152: begin
               f.n = 2'd2; f.chars[0] = 7'h4F; f.chars[1] = 7'h45;
            end
            21'h0E6: begin
               f.n = 2'd2; f.chars[0] = 7'h61; f.chars[1] = 7'h65;
            end
            21'h0C6: begin
               f.n = 2'd2; f.chars[0] = 7'h41; f.chars[1] = 7'h45;
            end
            21'h2019:                            f.chars[0] = 7'h27;
            21'h2013, 21'h2014:                  f.chars[0] = 7'h2D;
            default:                             f.chars[0] = (cp < 21'h20) ? CH_SPACE : CH_QMARK;
         endcase
      end
      return f;
   endfunction

   esc_phase_type phase_ff, phase_in;
   logic [15:0]   hex_ff, hex_in;
   logic          bad_ff, bad_in;
   logic [2:0]    need_ff, need_in;
   logic [2:0]    seen_ff, seen_in;
   logic [20:0]   cp_ff, cp_in;

   hex_type       hd;
   logic [15:0]   hex_new;
   logic [20:0]   acc_new;
   logic          is_cont;
   logic          in_hex;
   logic [20:0]   fold_arg;
   fold_type      fo;
   logic [2:0]    n;
   logic [CHAR_SLOTS-1:0][6:0] ch;
   logic          start;

   always_comb begin
      hd       = hex_digit(in_byte);
      hex_new  = hd.ok ? {hex_ff[11:0], hd.val} : hex_ff;
      acc_new  = {cp_ff[14:0], in_byte[5:0]};
      is_cont  = (in_byte[7:6] == 2'b10);
      in_hex   = (phase_ff == ESC_HEX0) || (phase_ff == ESC_HEX1) ||
                 (phase_ff == ESC_HEX2) || (phase_ff == ESC_HEX3);
      fold_arg = in_hex ? {5'd0, hex_new} :
                 ((need_ff != 3'd0) && is_cont) ? acc_new : {13'd0, in_byte};
      fo       = fold_code(fold_arg);
   end

   always_comb begin
      phase_in = phase_ff;
      hex_in   = hex_ff;
      bad_in   = bad_ff;
      need_in  = need_ff;
      seen_in  = seen_ff;
      cp_in    = cp_ff;
      n        = 3'd0;
      ch       = {CHAR_SLOTS{CH_QMARK}};
      start    = 1'b0;

      if (has_byte) begin
         case (phase_ff)
            ESC_BACKSLASH: begin
               if (in_byte == 8'h75) begin
                  phase_in = ESC_HEX0;
                  hex_in   = 16'd0;
                  bad_in   = 1'b0;
               end else begin
                  phase_in = ESC_IDLE;
                  if (in_byte == 8'h6E || in_byte == 8'h72 || in_byte == 8'h74) begin
                     ch[0] = CH_SPACE;
                  end else if (in_byte == 8'h22 || in_byte == 8'h5C || in_byte == 8'h2F) begin
                     ch[0] = in_byte[6:0];
                  end else begin
                     ch[0] = CH_QMARK;
                  end
                  n = 3'd1;
               end
            end
            ESC_HEX0, ESC_HEX1, ESC_HEX2: begin
               hex_in = hex_new;
               bad_in = bad_ff | ~hd.ok;
               case (phase_ff)
                  ESC_HEX0: phase_in = ESC_HEX1;
                  ESC_HEX1: phase_in = ESC_HEX2;
                  default:  phase_in = ESC_HEX3;
               endcase
            end
            ESC_HEX3: begin
               phase_in = ESC_IDLE;
               hex_in   = 16'd0;
               bad_in   = 1'b0;
               if (bad_ff || !hd.ok) begin
                  ch[0] = CH_QMARK;
                  n     = 3'd1;
               end else begin
                  ch[2:0] = fo.chars;
                  n       = {1'b0, fo.n};
               end
            end
            default: begin
               if (need_ff != 3'd0 && is_cont) begin
                  cp_in   = acc_new;
                  seen_in = seen_ff + 3'd1;
                  if (seen_in >= need_ff) begin
                     ch[2:0] = fo.chars;
                     n       = {1'b0, fo.n};
                     need_in = 3'd0;
                     seen_in = 3'd0;
                     cp_in   = 21'd0;
                  end
               end else begin
                  if (need_ff != 3'd0) begin
                     for (int k = 0; k < 3; k++) begin
                        if (3'(k) < seen_ff) begin
                           ch[n[1:0]] = CH_QMARK;
                           n          = n + 3'd1;
                        end
                     end
                     need_in = 3'd0;
                     seen_in = 3'd0;
                     cp_in   = 21'd0;
                  end
                  start = 1'b1;
               end
            end
         endcase

         if (start) begin
            if (in_byte == 8'h5C) begin
               phase_in = ESC_BACKSLASH;
            end else if (!in_byte[7]) begin
               ch[n[1:0]] = fo.chars[0];
               n          = n + 3'd1;
            end else if (in_byte[7:5] == 3'b110) begin
               need_in = 3'd2; seen_in = 3'd1; cp_in = {16'd0, in_byte[4:0]};
            end else if (in_byte[7:4] == 4'b1110) begin
               need_in = 3'd3; seen_in = 3'd1; cp_in = {17'd0, in_byte[3:0]};
            end else if (in_byte[7:3] == 5'b11110) begin
               need_in = 3'd4; seen_in = 3'd1; cp_in = {18'd0, in_byte[2:0]};
            end else begin
               ch[n[1:0]] = CH_QMARK;
               n          = n + 3'd1;
            end
         end
      end

      if (final_req) begin
         if (phase_in != ESC_IDLE) begin
            ch[n[1:0]] = CH_QMARK;
            n          = n + 3'd1;
         end
         if (need_in != 3'd0) begin
            for (int k = 0; k < 3; k++) begin
               if (3'(k) < seen_in) begin
                  ch[n[1:0]] = CH_QMARK;
                  n          = n + 3'd1;
               end
            end
         end
         phase_in = ESC_IDLE;
         hex_in   = 16'd0;
         bad_in   = 1'b0;
         need_in  = 3'd0;
         seen_in  = 3'd0;
         cp_in    = 21'd0;
      end
   end

   always_comb begin
      push_entry.n     = n;
      push_entry.chars = ch;
      push_entry.term  = final_req;
      push             = accept && (n != 3'd0 || final_req);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ESC_IDLE;
         hex_ff   <= '0;
         bad_ff   <= 1'b0;
         need_ff  <= '0;
         seen_ff  <= '0;
         cp_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         bad_ff   <= bad_in;
         need_ff  <= need_in;
         seen_ff  <= seen_in;
         cp_ff    <= cp_in;
      end
   end

endmodule

// ===== sv/jsaf_queue.sv =====
// Short entry queue between the front decoder and the write sequencer.
// Depends on jsaf_pkg for the entry and status types.
module jsaf_queue
   import jsaf_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type status
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   entry_type       mem [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   assign head_entry       = mem[rd_ptr_ff];
   assign status.full      = (count_ff == CntW'(DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH)) else $error("queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty) else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("queue count did not advance on push");
`endif

endmodule

// ===== sv/jsaf_back.sv =====
// Write sequencer: turns queued character lists into buffer writes, one per cycle unless stalled.
// Depends on jsaf_pkg; holds the output position and the result register.
module jsaf_back
   import jsaf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [8:0]       eff_size,
   input  queue_status_type q_status,
   input  entry_type        head_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_write_pos,
   output logic [6:0]       rsp_write_char,
   output logic             rsp_is_terminator,
   output logic             rsp_last
);

   logic [2:0] k_ff, k_in;
   logic [8:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pos_ff, rsp_pos_in;
   logic [6:0] rsp_char_ff, rsp_char_in;
   logic       rsp_term_ff, rsp_term_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       chars_ok, term_ok, out_free, emit, is_char, is_last, fits;
   logic [2:0] eff_n, total;
   logic [8:0] wpos;

   always_comb begin
      chars_ok = (eff_size >= 9'd2);
      term_ok  = head_entry.term && (eff_size != 9'd0);
      eff_n    = chars_ok ? head_entry.n : 3'd0;
      total    = eff_n + {2'd0, term_ok};
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = q_status.not_empty && (total != 3'd0) && out_free;
      is_char  = (k_ff < eff_n);
      is_last  = (k_ff == total - 3'd1);
      pop      = q_status.not_empty && ((total == 3'd0) || (emit && is_last));
      fits     = (pos_ff + 9'd1) < eff_size;

      if (is_char) begin
         wpos        = fits ? pos_ff : eff_size - 9'd2;
         rsp_char_in = fits ? head_entry.chars[k_ff[1:0]] : CH_DOT;
      end else begin
         wpos        = (pos_ff < eff_size) ? pos_ff : eff_size - 9'd1;
         rsp_char_in = CH_NUL;
      end
      rsp_pos_in   = wpos[7:0];
      rsp_term_in  = !is_char;
      rsp_last_in  = is_last;
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

      pos_in = pos_ff;
      if (pop && head_entry.term) begin
         pos_in = 9'd0;
      end else if (emit && is_char && fits) begin
         pos_in = pos_ff + 9'd1;
      end

      k_in = k_ff;
      if (pop) begin
         k_in = 3'd0;
      end else if (emit) begin
         k_in = k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pos_ff  <= rsp_pos_in;
         rsp_char_ff <= rsp_char_in;
         rsp_term_ff <= rsp_term_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_pos     = rsp_pos_ff;
   assign rsp_write_char    = rsp_char_ff;
   assign rsp_is_terminator = rsp_term_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== sv/json_string_ascii_folder.sv =====
// Top level of the JSON string ASCII folder: size register, front decoder, queue, sequencer.
// Depends on jsaf_pkg, jsaf_front, jsaf_queue and jsaf_back.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   has_byte, in_byte, final_req
//   rsp      out        rsp_valid/rsp_stall   write_pos, write_char, is_terminator, last
//   csr      in         csr_valid/csr_ready   buffer_size
//
// An item is decoded in the cycle it is accepted; an item that yields m writes leaves the
// write sequencer one write per cycle into the output register unless rsp_stall holds it.
// Items of at most one write go one per cycle unless stalled; queue absorbs longer bursts.
// Reset is synchronous; buffer_size returns to 256, all decode state clears, no sweep.
// req_stall rises while the queue is full; rsp_stall holds the output register.
module json_string_ascii_folder
   import jsaf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_has_byte,
   input  logic [7:0] req_in_byte,
   input  logic       req_final_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_write_pos,
   output logic [6:0] rsp_write_char,
   output logic       rsp_is_terminator,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_buffer_size
);

   logic [8:0]       buffer_size_ff, buffer_size_in;
   logic [8:0]       eff_size;
   logic             accept;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head_entry;
   queue_status_type q_status;

   assign csr_ready      = 1'b1;
   assign buffer_size_in = (csr_valid && csr_ready) ? csr_buffer_size : buffer_size_ff;
   assign eff_size       = (buffer_size_ff > SIZE_CAP) ? SIZE_CAP : buffer_size_ff;
   assign req_stall      = q_status.full;
   assign accept         = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= SIZE_RESET;
      end else begin
         buffer_size_ff <= buffer_size_in;
      end
   end

   jsaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .has_byte   (req_has_byte),
      .in_byte    (req_in_byte),
      .final_req  (req_final_req),
      .push       (push),
      .push_entry (push_entry)
   );

   jsaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   jsaf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .eff_size          (eff_size),
      .q_status          (q_status),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_pos     (rsp_write_pos),
      .rsp_write_char    (rsp_write_char),
      .rsp_is_terminator (rsp_is_terminator),
      .rsp_last          (rsp_last)
   );

endmodule
